### hdl/psff_pkg.sv
// ----------------------------------------------------------------------------
// psff_pkg
// Shared types and constants for the pcm sample fifo with fade envelope.
// ----------------------------------------------------------------------------
package psff_pkg;

    // default queue depth in samples
    localparam int QUEUE_DEPTH_DEF = 4096;

    // fixed field widths
    localparam int SAMPLE_W = 16;
    localparam int FL_W     = 11;
    localparam int COUNT_W  = 13;
    localparam int KIND_W   = 2;

    // fade length after reset
    localparam logic [FL_W-1:0] FADE_LEN_RST = 11'd220;

    // product of a sample and a fade level, and its magnitude
    localparam int PROD_W    = SAMPLE_W + FL_W + 1;
    localparam int MAG_W     = SAMPLE_W + FL_W - 1;
    localparam int DIV_STEPS = MAG_W;
    localparam int DCNT_W    = $clog2(DIV_STEPS);

    // saturation bounds as magnitudes
    localparam logic [MAG_W-1:0] POS_MAX_MAG = MAG_W'(32767);
    localparam logic [MAG_W-1:0] NEG_MAX_MAG = MAG_W'(32768);
    localparam logic [SAMPLE_W-1:0] SAT_POS  = 16'h7fff;
    localparam logic [SAMPLE_W-1:0] SAT_NEG  = 16'h8000;

    // operation codes
    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH  = 2'd0,
        KIND_PULL  = 2'd1,
        KIND_CLEAR = 2'd2,
        KIND_NOP   = 2'd3
    } t_kind;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MULT,
        ST_ABS,
        ST_DIV,
        ST_SAT,
        ST_DONE
    } t_state;

endpackage

### hdl/psff_ram.sv
// ----------------------------------------------------------------------------
// psff_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module psff_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/pcm_sample_fifo_with_fade.sv
// ----------------------------------------------------------------------------
// pcm_sample_fifo_with_fade
// Sample queue with a linear fade envelope applied on each pull.
// ----------------------------------------------------------------------------
// sequence: push, clear and no-op go from the exec state to o_done, as does a pull
//   on an empty queue; a pull with data passes through multiply, magnitude, the
//   shared 1-bit-per-cycle restoring divider (26 steps) and saturation first
// throughput: one item at a time, start is taken only while busy is low
// the result is shown for one cycle with o_done, the receiver cannot stall
// reset (synchronous, active low): queue empty, fade level 0, fade length 220
module pcm_sample_fifo_with_fade #(
    parameter int QUEUE_DEPTH = psff_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [psff_pkg::KIND_W-1:0]       i_kind,
    input  logic signed [psff_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                              i_cfg_we,
    input  logic [psff_pkg::FL_W-1:0]         i_cfg_wdata,
    output logic                              o_done,
    output logic signed [psff_pkg::SAMPLE_W-1:0] o_out_sample,
    output logic                              o_out_valid,
    output logic [psff_pkg::COUNT_W-1:0]      o_queued_count,
    output logic                              o_overflow
);

    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
    localparam int CMP_W  = (FILL_W > psff_pkg::FL_W) ? FILL_W : psff_pkg::FL_W;
    localparam int SW     = psff_pkg::SAMPLE_W;
    localparam int FW     = psff_pkg::FL_W;
    localparam int MW     = psff_pkg::MAG_W;

    // control registers
    psff_pkg::t_state r_state, n_state;
    logic [PTR_W-1:0]  r_rptr, n_rptr;
    logic [PTR_W-1:0]  r_wptr, n_wptr;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic [FW-1:0]     r_fade, n_fade;
    logic [FW-1:0]     r_fade_len;
    logic [psff_pkg::DCNT_W-1:0] r_cnt, n_cnt;

    // payload registers
    psff_pkg::t_kind           r_kind;
    logic signed [SW-1:0]      r_sample;
    logic [FW-1:0]             r_fl, n_fl;
    logic signed [psff_pkg::PROD_W-1:0] r_prod, n_prod;
    logic                      r_neg, n_neg;
    logic [MW-1:0]             r_quo, n_quo;
    logic [FW-1:0]             r_rem, n_rem;
    logic [SW-1:0]             r_out_sample, n_out_sample;
    logic                      r_out_valid, n_out_valid;
    logic                      r_ovf, n_ovf;

    // datapath helpers
    logic                      accept;
    logic                      ram_we;
    logic [SW-1:0]             ram_rdata;
    logic [FW-1:0]             fl_eff;
    logic [FW-1:0]             target;
    logic                      full;
    logic                      empty;
    logic [psff_pkg::PROD_W-1:0] prod_mag;
    logic [FW:0]               rem_sh;
    logic                      rem_ge;

    assign accept = start && (r_state == psff_pkg::ST_IDLE);
    assign full   = (r_fill == FILL_W'(QUEUE_DEPTH));
    assign empty  = (r_fill == '0);
    assign fl_eff = (r_fade_len == '0) ? FW'(1) : r_fade_len;
    assign target = (CMP_W'(r_fill) <= CMP_W'(fl_eff)) ? '0 : fl_eff;
    assign prod_mag = r_prod[psff_pkg::PROD_W-1] ? (-r_prod) : r_prod;
    assign rem_sh = {r_rem, r_quo[MW-1]};
    assign rem_ge = (rem_sh >= {1'b0, r_fl});

    // sample storage
    psff_ram #(
        .WIDTH (SW),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wptr),
        .i_wdata (r_sample),
        .i_raddr (r_rptr),
        .o_rdata (ram_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            psff_pkg::ST_IDLE: begin
                if (start) begin
                    n_state = psff_pkg::ST_EXEC;
                end
            end
            psff_pkg::ST_EXEC: begin
                if ((r_kind == psff_pkg::KIND_PULL) && !empty) begin
                    n_state = psff_pkg::ST_MULT;
                end else begin
                    n_state = psff_pkg::ST_DONE;
                end
            end
            psff_pkg::ST_MULT: n_state = psff_pkg::ST_ABS;
            psff_pkg::ST_ABS:  n_state = psff_pkg::ST_DIV;
            psff_pkg::ST_DIV: begin
                if (r_cnt == psff_pkg::DCNT_W'(psff_pkg::DIV_STEPS - 1)) begin
                    n_state = psff_pkg::ST_SAT;
                end
            end
            psff_pkg::ST_SAT:  n_state = psff_pkg::ST_DONE;
            psff_pkg::ST_DONE: n_state = psff_pkg::ST_IDLE;
            default:           n_state = psff_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        busy   = 1'b1;
        o_done = 1'b0;
        unique case (r_state)
            psff_pkg::ST_IDLE: busy = 1'b0;
            psff_pkg::ST_DONE: o_done = 1'b1;
            default: ;
        endcase
    end

    // queue update, fade step and the shared multiply / divide datapath
    always_comb begin
        n_rptr       = r_rptr;
        n_wptr       = r_wptr;
        n_fill       = r_fill;
        n_fade       = r_fade;
        n_cnt        = r_cnt;
        n_fl         = r_fl;
        n_prod       = r_prod;
        n_neg        = r_neg;
        n_quo        = r_quo;
        n_rem        = r_rem;
        n_out_sample = r_out_sample;
        n_out_valid  = r_out_valid;
        n_ovf        = r_ovf;
        ram_we       = 1'b0;
        case (r_state)
            psff_pkg::ST_EXEC: begin
                n_out_sample = '0;
                n_out_valid  = 1'b0;
                n_ovf        = 1'b0;
                n_fl         = fl_eff;
                unique case (r_kind)
                    psff_pkg::KIND_PUSH: begin
                        if (full) begin
                            n_ovf = 1'b1;
                        end else begin
                            ram_we = 1'b1;
                            n_wptr = (r_wptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
                            n_fill = r_fill + 1'b1;
                        end
                    end
                    psff_pkg::KIND_PULL: begin
                        if (!empty) begin
                            if (r_fade < target) begin
                                n_fade = r_fade + 1'b1;
                            end else if (r_fade > target) begin
                                n_fade = r_fade - 1'b1;
                            end
                            n_out_valid = 1'b1;
                            n_rptr = (r_rptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
                            n_fill = r_fill - 1'b1;
                        end
                    end
                    psff_pkg::KIND_CLEAR: begin
                        n_fill = '0;
                        n_rptr = r_wptr;
                    end
                    default: ;
                endcase
            end
            psff_pkg::ST_MULT: begin
                n_prod = psff_pkg::PROD_W'($signed(ram_rdata))
                       * psff_pkg::PROD_W'($signed({1'b0, r_fade}));
            end
            psff_pkg::ST_ABS: begin
                n_neg = r_prod[psff_pkg::PROD_W-1];
                n_quo = prod_mag[MW-1:0];
                n_rem = '0;
                n_cnt = '0;
            end
            psff_pkg::ST_DIV: begin
                n_rem = rem_ge ? FW'(rem_sh - {1'b0, r_fl}) : rem_sh[FW-1:0];
                n_quo = {r_quo[MW-2:0], rem_ge};
                n_cnt = r_cnt + 1'b1;
            end
            psff_pkg::ST_SAT: begin
                if (!r_neg) begin
                    n_out_sample = (r_quo > psff_pkg::POS_MAX_MAG) ? psff_pkg::SAT_POS
                                                                   : r_quo[SW-1:0];
                end else begin
                    n_out_sample = (r_quo > psff_pkg::NEG_MAX_MAG) ? psff_pkg::SAT_NEG
                                                                   : (-r_quo[SW-1:0]);
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= psff_pkg::ST_IDLE;
            r_rptr     <= '0;
            r_wptr     <= '0;
            r_fill     <= '0;
            r_fade     <= '0;
            r_cnt      <= '0;
            r_fade_len <= psff_pkg::FADE_LEN_RST;
        end else begin
            r_state <= n_state;
            r_rptr  <= n_rptr;
            r_wptr  <= n_wptr;
            r_fill  <= n_fill;
            r_fade  <= n_fade;
            r_cnt   <= n_cnt;
            if (i_cfg_we) begin
                r_fade_len <= i_cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind   <= psff_pkg::t_kind'(i_kind);
            r_sample <= i_sample;
        end
        r_fl         <= n_fl;
        r_prod       <= n_prod;
        r_neg        <= n_neg;
        r_quo        <= n_quo;
        r_rem        <= n_rem;
        r_out_sample <= n_out_sample;
        r_out_valid  <= n_out_valid;
        r_ovf        <= n_ovf;
    end

    assign o_out_sample   = $signed(r_out_sample);
    assign o_out_valid    = r_out_valid;
    assign o_overflow     = r_ovf;
    assign o_queued_count = psff_pkg::COUNT_W'(r_fill);

endmodule

### hdl/psff_checker.sv
// ----------------------------------------------------------------------------
// psff_checker
// Port-level checks for the pcm sample fifo with fade, bound to the top level.
// ----------------------------------------------------------------------------
module psff_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              start,
    input logic                              busy,
    input logic                              o_done,
    input logic                              o_out_valid,
    input logic                              o_overflow
);

    // an accepted item makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after accepting an item");

    // results appear only while an item is in work
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy)
        else $error("result strobe while idle");

    // one strobe per item, then the block is free again
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> (!o_done && !busy))
        else $error("result strobe not followed by idle");

    // a dropped push never reports a pulled sample
    a_ovf_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !(o_overflow && o_out_valid))
        else $error("overflow and valid sample in one item");

endmodule

bind pcm_sample_fifo_with_fade psff_checker u_psff_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_done      (o_done),
    .o_out_valid (o_out_valid),
    .o_overflow  (o_overflow)
);

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the pcm sample fifo with fade envelope. Items are
// issued through the start/busy handshake and mirrored into a behavioral
// queue with its own fade level, and every done strobe is compared with the
// oldest predicted response.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH       = psff_pkg::QUEUE_DEPTH_DEF;
    localparam int SW          = psff_pkg::SAMPLE_W;
    localparam int CW          = psff_pkg::COUNT_W;
    localparam int FW          = psff_pkg::FL_W;
    localparam int KW          = psff_pkg::KIND_W;
    localparam int PW          = $clog2(DEPTH);
    localparam int STALL_LIMIT = 1000;
    localparam int PRINT_LIMIT = 100;

    // one response of the block
    typedef struct {
        logic signed [SW-1:0] out_sample;
        logic                 out_valid;
        logic [CW-1:0]        queued_count;
        logic                 overflow;
    } t_fifo_resp;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic [KW-1:0]        i_kind;
    logic signed [SW-1:0] i_sample;
    logic                 i_cfg_we;
    logic [FW-1:0]        i_cfg_wdata;
    logic                 o_done;
    logic signed [SW-1:0] o_out_sample;
    logic                 o_out_valid;
    logic [CW-1:0]        o_queued_count;
    logic                 o_overflow;

    // behavioral copy of the queue and envelope
    logic signed [SW-1:0] mdl_store [DEPTH];
    logic [PW-1:0]        mdl_rd       = '0;
    logic [PW-1:0]        mdl_wr       = '0;
    int                   mdl_fill     = 0;
    int                   mdl_level    = 0;
    int                   mdl_fade_len = int'(psff_pkg::FADE_LEN_RST);

    t_fifo_resp awaited_responses[$];
    int         error_count = 0;
    int         gap_pct     = 30;
    int         quiet_cycles = 0;

    pcm_sample_fifo_with_fade i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_kind         (i_kind),
        .i_sample       (i_sample),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_done         (o_done),
        .o_out_sample   (o_out_sample),
        .o_out_valid    (o_out_valid),
        .o_queued_count (o_queued_count),
        .o_overflow     (o_overflow)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    task automatic report_mismatch(string msg);
        if (error_count < PRINT_LIMIT) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
        error_count++;
    endtask

    // queue and fade envelope update for one accepted item
    function automatic t_fifo_resp apply_fifo_op(psff_pkg::t_kind k,
                                                 logic signed [SW-1:0] s);
        t_fifo_resp r;
        int         eff_len;
        int         goal;
        int         scaled;
        r = '{default: '0};
        case (k)
            psff_pkg::KIND_PUSH: begin
                if (mdl_fill >= DEPTH) begin
                    r.overflow = 1'b1;
                end else begin
                    mdl_store[mdl_wr] = s;
                    mdl_wr = mdl_wr + 1'b1;
                    mdl_fill++;
                end
            end
            psff_pkg::KIND_PULL: begin
                if (mdl_fill != 0) begin
                    // zero length behaves as one
                    eff_len = (mdl_fade_len == 0) ? 1 : mdl_fade_len;
                    goal = (mdl_fill <= eff_len) ? 0 : eff_len;
                    if (mdl_level < goal) begin
                        mdl_level++;
                    end else if (mdl_level > goal) begin
                        mdl_level--;
                    end
                    scaled = (int'(mdl_store[mdl_rd]) * mdl_level) / eff_len;
                    // level above length can push the product out of range
                    if (scaled > 32767) scaled = 32767;
                    if (scaled < -32768) scaled = -32768;
                    r.out_sample = SW'(scaled);
                    r.out_valid = 1'b1;
                    mdl_rd = mdl_rd + 1'b1;
                    mdl_fill--;
                end
            end
            psff_pkg::KIND_CLEAR: begin
                mdl_fill = 0;
                mdl_rd = mdl_wr;
            end
            default: begin
            end
        endcase
        r.queued_count = CW'(mdl_fill);
        return r;
    endfunction

    function automatic logic signed [SW-1:0] rand_sample();
        case ($urandom_range(15))
            0: return psff_pkg::SAT_POS;
            1: return psff_pkg::SAT_NEG;
            2: return '0;
            3: return 16'sd1;
            4: return -16'sd1;
            default: return SW'($urandom);
        endcase
    endfunction

    // issue one item and wait for the handshake, then maybe idle a burst
    task automatic issue_op(psff_pkg::t_kind k, logic signed [SW-1:0] s);
        start    <= 1'b1;
        i_kind   <= k;
        i_sample <= s;
        do @(posedge i_clk); while (busy !== 1'b0);
        awaited_responses.push_back(apply_fifo_op(k, s));
        if ($urandom_range(99) < gap_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
    endtask

    // hold off until every response is in and the block is idle
    task automatic wait_until_drained();
        start <= 1'b0;
        do @(posedge i_clk); while (awaited_responses.size() != 0 || busy !== 1'b0);
    endtask

    task automatic set_fade_length(int len);
        wait_until_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= FW'(len);
        @(posedge i_clk);
        mdl_fade_len = len;
        i_cfg_we <= 1'b0;
    endtask

    // each operation with field extremes, at the reset fade length
    task automatic test_basic_ops();
        issue_op(psff_pkg::KIND_PULL, 16'sh7fff);
        issue_op(psff_pkg::KIND_NOP, 16'sh1234);
        issue_op(psff_pkg::KIND_CLEAR, -16'sd1);
        issue_op(psff_pkg::KIND_PUSH, psff_pkg::SAT_POS);
        issue_op(psff_pkg::KIND_PUSH, psff_pkg::SAT_NEG);
        issue_op(psff_pkg::KIND_PUSH, '0);
        issue_op(psff_pkg::KIND_PUSH, 16'sd1);
        issue_op(psff_pkg::KIND_PUSH, -16'sd1);
        issue_op(psff_pkg::KIND_PUSH, 16'sh5555);
        issue_op(psff_pkg::KIND_PUSH, SW'(16'haaaa));
        issue_op(psff_pkg::KIND_NOP, SW'($urandom));
        repeat (8) issue_op(psff_pkg::KIND_PULL, -16'sd1);
        issue_op(psff_pkg::KIND_PUSH, rand_sample());
        issue_op(psff_pkg::KIND_CLEAR, rand_sample());
        issue_op(psff_pkg::KIND_PULL, rand_sample());
    endtask

    // short ramp up and down at the reset fade length
    task automatic test_reset_length();
        repeat (225) issue_op(psff_pkg::KIND_PUSH, rand_sample());
        repeat (10) issue_op(psff_pkg::KIND_PULL, rand_sample());
        issue_op(psff_pkg::KIND_CLEAR, rand_sample());
    endtask

    // ramp to full level, then shrink the length under the level
    task automatic test_fade_extremes();
        set_fade_length(64);
        repeat (150) issue_op(psff_pkg::KIND_PUSH, rand_sample());
        repeat (80) issue_op(psff_pkg::KIND_PULL, rand_sample());
        set_fade_length(0);
        repeat (10) issue_op(psff_pkg::KIND_PULL, rand_sample());
        set_fade_length(2047);
        repeat (10) issue_op(psff_pkg::KIND_PULL, rand_sample());
        set_fade_length(1024);
        issue_op(psff_pkg::KIND_PULL, rand_sample());
        issue_op(psff_pkg::KIND_CLEAR, rand_sample());
    endtask

    // count past 255 samples, drain part, clear, then pull the queue dry
    task automatic test_deep_queue();
        gap_pct = 10;
        set_fade_length(16);
        repeat (260) issue_op(psff_pkg::KIND_PUSH, rand_sample());
        repeat (20) issue_op(psff_pkg::KIND_PULL, rand_sample());
        issue_op(psff_pkg::KIND_CLEAR, rand_sample());
        repeat (10) issue_op(psff_pkg::KIND_PUSH, rand_sample());
        repeat (12) issue_op(psff_pkg::KIND_PULL, rand_sample());
        gap_pct = 30;
    endtask

    // push and pull bursts around the fade length, with some noise
    task automatic test_random_traffic();
        int  left;
        int  n;
        int  pick;
        bit  paused;
        for (int phase = 0; phase < 10; phase++) begin
            case (phase)
                0: set_fade_length(1);
                1: set_fade_length(0);
                2: set_fade_length(2047);
                5: set_fade_length($urandom_range(41, 2047));
                default: set_fade_length($urandom_range(2, 40));
            endcase
            // no idling on some phases and at the end of the run
            gap_pct = (phase >= 8 || phase % 3 == 1) ? 0 : 35;
            left = 60;
            paused = 1'b0;
            while (left > 0) begin
                if (phase == 3 && !paused && left <= 30) begin
                    wait_until_drained();
                    paused = 1'b1;
                end
                pick = $urandom_range(99);
                if (mdl_fill > 150) pick = 60;
                if (pick < 45) begin
                    n = $urandom_range(1, 60);
                    for (int i = 0; i < n && left > 0; i++, left--) begin
                        issue_op(psff_pkg::KIND_PUSH, rand_sample());
                    end
                end else if (pick < 88) begin
                    n = $urandom_range(1, mdl_fill + 4);
                    if (n > 60) n = 60;
                    for (int i = 0; i < n && left > 0; i++, left--) begin
                        issue_op(psff_pkg::KIND_PULL, rand_sample());
                    end
                end else if (pick < 94) begin
                    issue_op(psff_pkg::KIND_CLEAR, rand_sample());
                    left--;
                end else begin
                    issue_op(psff_pkg::KIND_NOP, rand_sample());
                    left--;
                end
            end
        end
    endtask

    // response checker
    always @(posedge i_clk) begin : check_results
        t_fifo_resp want;
        if (i_rst_n === 1'b1 && o_done === 1'b1) begin
            if (awaited_responses.size() == 0) begin
                report_mismatch($sformatf("response with no item pending, count %0d",
                                          o_queued_count));
            end else begin
                want = awaited_responses[0];
                awaited_responses.delete(0);
                if (o_out_sample !== want.out_sample)
                    report_mismatch($sformatf("out_sample got %0d expected %0d",
                                              o_out_sample, want.out_sample));
                if (o_out_valid !== want.out_valid)
                    report_mismatch($sformatf("out_valid got %b expected %b",
                                              o_out_valid, want.out_valid));
                if (o_queued_count !== want.queued_count)
                    report_mismatch($sformatf("queued_count got %0d expected %0d",
                                              o_queued_count, want.queued_count));
                if (o_overflow !== want.overflow)
                    report_mismatch($sformatf("overflow got %b expected %b",
                                              o_overflow, want.overflow));
            end
        end
    end

    // watchdog on cycles with no handshake and no response
    always @(posedge i_clk) begin
        if ((start === 1'b1 && busy === 1'b0) || o_done === 1'b1) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // test sequence
    initial begin
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_kind      <= psff_pkg::KIND_NOP;
        i_sample    <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_basic_ops();
        test_reset_length();
        test_fade_extremes();
        test_deep_queue();
        test_random_traffic();

        wait_until_drained();
        repeat (40) @(posedge i_clk);
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
